// File: design/slip_frame_decoder_assert.svh
// Assertion macros shared by the SLIP frame decoder RTL.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef SLIP_FRAME_DECODER_ASSERT_SVH
`define SLIP_FRAME_DECODER_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define SFD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfd assertion failed");

// Check that cons holds in the cycle after ante
`define SFD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfd assertion failed");

`endif

// File: design/sfd_pkg.sv
// Package for the SLIP frame decoder: widths, SLIP codes, status codes, result type.
// Depends on nothing.
package sfd_pkg;

	localparam int SFD_BYTE_W    = 8;
	localparam int SFD_LEN_W     = 11;
	localparam int SFD_MAX_FRAME = 1024;
	localparam int SFD_LEN_MAX   = (1 << SFD_LEN_W) - 1;
	localparam int SFD_LIMIT_CAP = (SFD_MAX_FRAME > SFD_LEN_MAX) ? SFD_LEN_MAX : SFD_MAX_FRAME;
	localparam int SFD_CFG_RESET = 1024;

	localparam logic [SFD_BYTE_W-1:0] SFD_END     = 8'hC0;
	localparam logic [SFD_BYTE_W-1:0] SFD_ESC     = 8'hDB;
	localparam logic [SFD_BYTE_W-1:0] SFD_ESC_END = 8'hDC;
	localparam logic [SFD_BYTE_W-1:0] SFD_ESC_ESC = 8'hDD;

	typedef enum logic [1:0] {
		SFD_ST_OK     = 2'd0,
		SFD_ST_TRUNC  = 2'd1,
		SFD_ST_BADESC = 2'd2
	} sfd_status_t;

	typedef struct packed {
		logic                  has_data;
		logic [SFD_BYTE_W-1:0] payload_byte;
		logic                  frame_end;
		sfd_status_t           frame_status;
		logic [SFD_LEN_W-1:0]  frame_length;
	} sfd_result_t;

	// Clamp a written limit to the frame cap; zero acts as one
	function automatic logic [SFD_LEN_W-1:0] sfd_clamp_limit(input logic [SFD_LEN_W-1:0] v);
		logic [SFD_LEN_W-1:0] lim;
		lim = v;
		if (v > SFD_LIMIT_CAP[SFD_LEN_W-1:0]) begin
			lim = SFD_LIMIT_CAP[SFD_LEN_W-1:0];
		end
		if (lim == '0) begin
			lim = {{(SFD_LEN_W-1){1'b0}}, 1'b1};
		end
		return lim;
	endfunction

endpackage

// File: design/sfd_if.sv
// Valid/ready channel interfaces of the SLIP frame decoder: line bytes, results, config.
// Depends on sfd_pkg.
interface sfd_byte_if import sfd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [SFD_BYTE_W-1:0] line_byte;

	modport source (output valid, output line_byte, input ready);
	modport sink (input valid, input line_byte, output ready);
endinterface

interface sfd_res_if import sfd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  has_data;
	logic [SFD_BYTE_W-1:0] payload_byte;
	logic                  frame_end;
	logic [1:0]            frame_status;
	logic [SFD_LEN_W-1:0]  frame_length;

	modport source (output valid, output has_data, output payload_byte, output frame_end,
		output frame_status, output frame_length, input ready);
	modport sink (input valid, input has_data, input payload_byte, input frame_end,
		input frame_status, input frame_length, output ready);
endinterface

interface sfd_cfg_if import sfd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SFD_LEN_W-1:0] max_frame_len;

	modport source (output valid, output max_frame_len, input ready);
	modport sink (input valid, input max_frame_len, output ready);
endinterface

// File: design/sfd_core.sv
// SLIP decode stage: input byte register, escape/count state, frame limit register.
// Depends on sfd_pkg.
module sfd_core import sfd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rx_valid,
	input  logic [SFD_BYTE_W-1:0] rx_byte,
	output logic                  rx_ready,
	input  logic                  cfg_valid,
	input  logic [SFD_LEN_W-1:0]  cfg_data,
	input  logic                  res_space,
	output logic                  res_push,
	output sfd_result_t           res_data
);

	logic                  valid_s1;
	logic [SFD_BYTE_W-1:0] byte_s1;
	logic                  esc_q;
	logic [SFD_LEN_W-1:0]  count_q;
	logic [SFD_LEN_W-1:0]  limit_q;

	logic                  fire;
	logic                  emit;
	logic                  is_pay;
	logic [SFD_BYTE_W-1:0] pay_data;
	logic                  esc_d;
	logic [SFD_LEN_W-1:0]  count_d;
	logic [SFD_LEN_W-1:0]  inc;
	sfd_result_t           res;

	// Advance the held byte when the result buffer has room
	assign fire     = valid_s1 && res_space;
	assign rx_ready = !valid_s1 || fire;
	assign inc      = count_q + {{(SFD_LEN_W-1){1'b0}}, 1'b1};

	// Hold the input stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_ready) begin
			valid_s1 <= rx_valid;
		end
	end

	// Capture the accepted line byte
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// Update frame state and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			count_q <= '0;
			limit_q <= sfd_clamp_limit(SFD_CFG_RESET[SFD_LEN_W-1:0]);
		end else begin
			if (fire) begin
				esc_q   <= esc_d;
				count_q <= count_d;
			end
			if (cfg_valid) begin
				limit_q <= sfd_clamp_limit(cfg_data);
			end
		end
	end

	// Decode one byte against the escape flag and payload count
	always_comb begin
		is_pay   = 1'b0;
		pay_data = byte_s1;
		emit     = 1'b0;
		res      = '0;
		esc_d    = esc_q;
		count_d  = count_q;
		if (esc_q) begin
			esc_d = 1'b0;
			if (byte_s1 == SFD_ESC_END) begin
				is_pay   = 1'b1;
				pay_data = SFD_END;
			end else if (byte_s1 == SFD_ESC_ESC) begin
				is_pay   = 1'b1;
				pay_data = SFD_ESC;
			end else begin
				emit             = 1'b1;
				res.frame_end    = 1'b1;
				res.frame_status = SFD_ST_BADESC;
				res.frame_length = count_q;
				count_d          = '0;
			end
		end else if (byte_s1 == SFD_END) begin
			// Drop END while no payload has arrived
			if (count_q != '0) begin
				emit             = 1'b1;
				res.frame_end    = 1'b1;
				res.frame_status = SFD_ST_OK;
				res.frame_length = count_q;
				count_d          = '0;
			end
		end else if (byte_s1 == SFD_ESC) begin
			esc_d = 1'b1;
		end else begin
			is_pay = 1'b1;
		end

		// Deliver a payload byte, cut the frame at the limit
		if (is_pay) begin
			emit             = 1'b1;
			res.has_data     = 1'b1;
			res.payload_byte = pay_data;
			if (inc >= limit_q) begin
				res.frame_end    = 1'b1;
				res.frame_status = SFD_ST_TRUNC;
				res.frame_length = inc;
				count_d          = '0;
				esc_d            = 1'b0;
			end else begin
				count_d = inc;
			end
		end
	end

	assign res_push = fire && emit;
	assign res_data = res;

endmodule

// File: design/sfd_out_buf.sv
// Two-entry result buffer between the decode stage and the result channel.
// Depends on sfd_pkg.
module sfd_out_buf import sfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  sfd_result_t push_data,
	output logic        space,
	output logic        out_valid,
	input  logic        out_ready,
	output sfd_result_t out_data
);

	sfd_result_t entry_q [2];
	logic        wr_q;
	logic        rd_q;
	logic [1:0]  cnt_q;
	logic        pop;

	assign space     = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = entry_q[rd_q];
	assign pop       = out_valid && out_ready;

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Store the pushed item
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

endmodule

// File: design/slip_frame_decoder.sv
// Top level of the SLIP frame decoder: decode stage plus result buffer.
// Depends on sfd_pkg, sfd_if, sfd_core, sfd_out_buf and slip_frame_decoder_assert.svh.
//
// Decodes a SLIP byte stream at one line byte per clock while the output buffer
// has room. A byte accepted on rx is registered, decoded in the next cycle against
// the escape flag and payload count, and its result (if any) is pushed into a
// two-entry output buffer that offers it on res. Leading END bytes and an ESC that
// opens an escape give no result. rx keeps accepting while results wait, until the
// output buffer is full and the registered byte cannot move. The limit written on
// cfg is clamped to the frame cap (zero acts as one) and takes effect for the next
// byte; cfg is always ready and should be written while the block is idle.
`include "slip_frame_decoder_assert.svh"

module slip_frame_decoder import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfd_byte_if.sink  rx,
	sfd_res_if.source res,
	sfd_cfg_if.sink   cfg
);

	logic        res_space;
	logic        res_push;
	sfd_result_t res_data;
	sfd_result_t out_data;

	// Decode stage
	sfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx.valid),
		.rx_byte   (rx.line_byte),
		.rx_ready  (rx.ready),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.max_frame_len),
		.res_space (res_space),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Result buffer
	sfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res_data),
		.space     (res_space),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.out_data  (out_data)
	);

	assign cfg.ready        = 1'b1;
	assign res.has_data     = out_data.has_data;
	assign res.payload_byte = out_data.payload_byte;
	assign res.frame_end    = out_data.frame_end;
	assign res.frame_status = out_data.frame_status;
	assign res.frame_length = out_data.frame_length;

	// A result that does not close a frame carries no status or length
	`SFD_ASSERT_NOW(a_open_frame_clean, res.valid && !res.frame_end, res.frame_status == SFD_ST_OK && res.frame_length == '0)

	// A result without data must close a frame and carry a zero byte
	`SFD_ASSERT_NOW(a_nodata_closes, res.valid && !res.has_data, res.frame_end && res.payload_byte == '0)

	// Truncation always comes with the byte that reached the limit
	`SFD_ASSERT_NOW(a_trunc_has_data, res.valid && res.frame_end && res.frame_status == SFD_ST_TRUNC, res.has_data)

	// A result pushed into an empty buffer is offered in the next cycle
	`SFD_ASSERT_NEXT(a_push_shows, res_push && !res.valid, res.valid)

endmodule

// File: dv/slip_frame_decoder_test.sv
// Self-checking bench for slip_frame_decoder: directed SLIP bytes, then random frames and noise.
// Results are predicted per line byte and compared in order with the res channel.
// Depends on sfd_pkg, sfd_if and the slip_frame_decoder RTL.
module slip_frame_decoder_test import sfd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 120;
	localparam int PHASE_ITEMS  = 70;
	localparam int DIR_ROWS     = 28;

	typedef logic [SFD_LEN_W-1:0]  len_t;
	typedef logic [SFD_BYTE_W-1:0] byte_t;

	typedef enum logic {
		STEP_BYTE,
		STEP_LIMIT
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		len_t        value;
		logic        typed;
		logic        typed_has;
		sfd_result_t res;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sfd_byte_if line_ch();
	sfd_res_if  res_ch();
	sfd_cfg_if  cfg_ch();

	slip_frame_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (line_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Decoder state mirrored by the bench
	logic        esc_pending = 1'b0;
	len_t        pay_count   = '0;
	len_t        limit_raw   = len_t'(SFD_CFG_RESET);
	sfd_result_t decoded_due[$];

	int  mismatches  = 0;
	int  items_sent  = 0;
	int  cycles      = 0;
	int  hold_left   = 0;
	bit  hold_start  = 1'b0;
	bit  burst       = 1'b0;

	stim_row_t dir_rows [DIR_ROWS];

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("slip_frame_decoder_test NOT OK");
			$finish;
		end
	end

	// Effective frame limit: cap at the frame maximum, zero acts as one
	function automatic len_t cut_limit();
		len_t lim;
		lim = (limit_raw > len_t'(SFD_MAX_FRAME)) ? len_t'(SFD_MAX_FRAME) : limit_raw;
		if (lim == '0) begin
			lim = len_t'(1);
		end
		return lim;
	endfunction

	// Count one payload byte and cut the frame when it reaches the limit
	function automatic void count_payload(input byte_t d, output sfd_result_t r);
		r = '0;
		pay_count = pay_count + len_t'(1);
		r.has_data = 1'b1;
		r.payload_byte = d;
		if (pay_count >= cut_limit()) begin
			r.frame_end = 1'b1;
			r.frame_status = SFD_ST_TRUNC;
			r.frame_length = pay_count;
			pay_count = '0;
			esc_pending = 1'b0;
		end
	endfunction

	// Decode one line byte; return 1 when it yields a result
	function automatic bit slip_decode(input byte_t b, output sfd_result_t r);
		r = '0;
		if (esc_pending) begin
			esc_pending = 1'b0;
			if (b == SFD_ESC_END) begin
				count_payload(SFD_END, r);
				return 1'b1;
			end
			if (b == SFD_ESC_ESC) begin
				count_payload(SFD_ESC, r);
				return 1'b1;
			end
			r.frame_end = 1'b1;
			r.frame_status = SFD_ST_BADESC;
			r.frame_length = pay_count;
			pay_count = '0;
			return 1'b1;
		end
		if (b == SFD_END) begin
			if (pay_count == '0) begin
				return 1'b0;
			end
			r.frame_end = 1'b1;
			r.frame_status = SFD_ST_OK;
			r.frame_length = pay_count;
			pay_count = '0;
			return 1'b1;
		end
		if (b == SFD_ESC) begin
			esc_pending = 1'b1;
			return 1'b0;
		end
		count_payload(b, r);
		return 1'b1;
	endfunction

	// Table row builders
	function automatic stim_row_t row_b(input byte_t b);
		stim_row_t s;
		s = '0;
		s.kind = STEP_BYTE;
		s.value = len_t'(b);
		return s;
	endfunction

	function automatic stim_row_t row_n(input byte_t b);
		stim_row_t s;
		s = row_b(b);
		s.typed = 1'b1;
		return s;
	endfunction

	function automatic stim_row_t row_x(input byte_t b, input logic has, input byte_t d,
			input sfd_status_t st, input len_t len);
		stim_row_t s;
		s = row_n(b);
		s.typed_has = 1'b1;
		s.res.has_data = has;
		s.res.payload_byte = d;
		s.res.frame_end = 1'b1;
		s.res.frame_status = st;
		s.res.frame_length = len;
		return s;
	endfunction

	function automatic stim_row_t row_c(input len_t v);
		stim_row_t s;
		s = '0;
		s.kind = STEP_LIMIT;
		s.value = v;
		return s;
	endfunction

	// Any byte except END and ESC
	function automatic byte_t plain_byte();
		byte_t b;
		do begin
			b = byte_t'($urandom_range(0, 255));
		end while (b == SFD_END || b == SFD_ESC);
		return b;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("mismatch at %0t: %s", $time, msg);
		end
	endtask

	// Offer one line byte, wait for the handshake, then predict its result
	task automatic send_byte(input stim_row_t row);
		int          gap;
		bit          taken;
		bit          got;
		sfd_result_t r;
		gap = 0;
		if (!burst && $urandom_range(0, 99) < 26) begin
			gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			line_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		line_ch.valid <= 1'b1;
		line_ch.line_byte <= row.value[SFD_BYTE_W-1:0];
		do begin
			@(negedge clk);
			taken = line_ch.ready;
			@(posedge clk);
		end while (!taken);
		got = slip_decode(row.value[SFD_BYTE_W-1:0], r);
		if (row.typed) begin
			got = row.typed_has;
			r = row.res;
		end
		if (got) begin
			decoded_due.push_back(r);
		end
		items_sent++;
	endtask

	// Stop offering and wait until every expected result is out
	task automatic drain_line();
		line_ch.valid <= 1'b0;
		while (decoded_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input len_t v);
		bit taken;
		cfg_ch.valid <= 1'b1;
		cfg_ch.max_frame_len <= v;
		do begin
			@(negedge clk);
			taken = cfg_ch.ready;
			@(posedge clk);
		end while (!taken);
		cfg_ch.valid <= 1'b0;
		limit_raw = v;
	endtask

	// Well-formed frame: optional leading ENDs, payload with escapes, closing END
	task automatic send_frame(input int plen);
		int lead;
		int k;
		lead = $urandom_range(0, 2);
		for (k = 0; k < lead; k++) begin
			send_byte(row_b(SFD_END));
		end
		for (k = 0; k < plen; k++) begin
			case ($urandom_range(0, 6))
				0: begin
					send_byte(row_b(SFD_ESC));
					send_byte(row_b(SFD_ESC_END));
				end
				1: begin
					send_byte(row_b(SFD_ESC));
					send_byte(row_b(SFD_ESC_ESC));
				end
				default: send_byte(row_b(plain_byte()));
			endcase
		end
		send_byte(row_b(SFD_END));
	endtask

	// Noise: SLIP codes and arbitrary bytes, including broken escapes
	task automatic send_noise(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: send_byte(row_b(SFD_END));
				1: send_byte(row_b(SFD_ESC));
				2: send_byte(row_b(SFD_ESC_END));
				3: send_byte(row_b(SFD_ESC_ESC));
				default: send_byte(row_b(byte_t'($urandom_range(0, 255))));
			endcase
		end
	endtask

	// Result receiver: random stalls, one long hold-off, one stall-free stretch
	initial begin
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_start) begin
				hold_start = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= burst || ($urandom_range(0, 99) >= 26);
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(negedge clk) begin
		sfd_result_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			if (decoded_due.size() == 0) begin
				report_mismatch("result with no expectation waiting");
			end else begin
				want = decoded_due.pop_front();
				if (res_ch.has_data !== want.has_data)
					report_mismatch($sformatf("has_data %b, want %b",
						res_ch.has_data, want.has_data));
				if (res_ch.payload_byte !== want.payload_byte)
					report_mismatch($sformatf("payload_byte %h, want %h",
						res_ch.payload_byte, want.payload_byte));
				if (res_ch.frame_end !== want.frame_end)
					report_mismatch($sformatf("frame_end %b, want %b",
						res_ch.frame_end, want.frame_end));
				if (res_ch.frame_status !== want.frame_status)
					report_mismatch($sformatf("frame_status %0d, want %0d",
						res_ch.frame_status, want.frame_status));
				if (res_ch.frame_length !== want.frame_length)
					report_mismatch($sformatf("frame_length %0d, want %0d",
						res_ch.frame_length, want.frame_length));
			end
		end
	end

	// Stimulus
	initial begin
		len_t phase_limit [8];
		len_t lim;
		int   p;
		int   goal;
		phase_limit = '{len_t'(1), len_t'(2), len_t'(7), len_t'(1025), len_t'(16),
			len_t'(0), len_t'(2047), len_t'(5)};
		dir_rows = '{
			row_n(SFD_END),                               // leading END is skipped
			row_b(8'h00),
			row_b(8'hFF),
			row_n(SFD_ESC),
			row_b(SFD_ESC_END),                           // escaped END
			row_n(SFD_ESC),
			row_b(SFD_ESC_ESC),                           // escaped ESC
			row_x(SFD_END, 1'b0, 8'h00, SFD_ST_OK, 11'd4),
			row_n(SFD_ESC),
			row_x(8'h41, 1'b0, 8'h00, SFD_ST_BADESC, 11'd0),
			row_b(8'h41),
			row_n(SFD_ESC),
			row_x(SFD_END, 1'b0, 8'h00, SFD_ST_BADESC, 11'd1),
			row_c(11'd0),                                 // zero limit acts as one
			row_x(8'h55, 1'b1, 8'h55, SFD_ST_TRUNC, 11'd1),
			row_n(SFD_ESC),
			row_x(SFD_ESC_END, 1'b1, SFD_END, SFD_ST_TRUNC, 11'd1),
			row_c(11'd3),
			row_b(8'h01),
			row_b(8'h02),
			row_c(11'd1),                                 // lower the limit mid-frame
			row_x(8'h03, 1'b1, 8'h03, SFD_ST_TRUNC, 11'd3),
			row_c(11'd2047),                              // above the cap
			row_b(8'h7F),
			row_x(SFD_END, 1'b0, 8'h00, SFD_ST_OK, 11'd1),
			row_n(SFD_ESC),
			row_x(SFD_ESC, 1'b0, 8'h00, SFD_ST_BADESC, 11'd0),
			row_n(SFD_END)
		};

		line_ch.valid <= 1'b0;
		line_ch.line_byte <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.max_frame_len <= '0;
		arst_n <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == STEP_LIMIT) begin
				drain_line();
				write_limit(dir_rows[i].value);
			end else begin
				send_byte(dir_rows[i]);
			end
		end

		// Random phases, one limit setting each
		for (p = 0; p < 9; p++) begin
			drain_line();
			write_limit((p < 8) ? phase_limit[p] : len_t'($urandom_range(0, 2047)));
			burst = (p == 2);
			if (p == 3) begin
				hold_start = 1'b1;
			end
			lim = cut_limit();
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				if ($urandom_range(0, 99) < 80) begin
					send_frame((lim <= 20) ? $urandom_range(0, lim + 2) : $urandom_range(0, 20));
				end else begin
					send_noise($urandom_range(1, 6));
				end
			end
		end
		burst = 1'b0;

		// One frame back at the reset limit
		drain_line();
		write_limit(len_t'(SFD_CFG_RESET));
		send_frame($urandom_range(1, 8));

		drain_line();
		if (mismatches == 0) begin
			$display("slip_frame_decoder_test OK");
		end else begin
			$display("slip_frame_decoder_test NOT OK");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/sfd_pkg.sv
design/sfd_if.sv
design/sfd_core.sv
design/sfd_out_buf.sv
design/slip_frame_decoder.sv
dv/slip_frame_decoder_test.sv
